### src/tlw_pkg.sv
`timescale 1ns / 1ps
package tlw_pkg;

   localparam int TLW_MAX_LINE = 32;
   localparam int QDEPTH       = 4;

   localparam int CSR_AW = 1;
   localparam int CSR_DW = 6;

   localparam logic [CSR_AW-1:0] CSR_LINE_WIDTH = 1'd0;
   localparam logic [CSR_AW-1:0] CSR_MAX_WRAPS  = 1'd1;

   localparam logic [5:0] LINE_WIDTH_RST = 6'd25;
   localparam logic [2:0] MAX_WRAPS_RST  = 3'd3;

   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NL    = 8'h0A;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       message_end;
   } tlw_req_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       char_valid;
      logic       line_end;
      logic       line_overflow;
   } tlw_rsp_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_CHAR,
      ACT_EOL
   } tlw_act_type;

   // one classified word: optional '?' first, then the action, then message end
   typedef struct packed {
      logic        qmark;
      tlw_act_type act;
      logic [7:0]  code;
      logic        last;
   } tlw_op_type;

   typedef enum logic [2:0] {
      ST_DISPATCH,
      ST_PUT,
      ST_RDWAIT,
      ST_WRAP,
      ST_TRIM2,
      ST_EOL,
      ST_FLUSH
   } tlw_state_type;

endpackage

### src/text_line_wrapper_utf8_replace.sv
`timescale 1ns / 1ps
// Flow: a word enters the 4-deep queue in the cycle it is accepted; the back end takes each
//   word from the queue head and sends its characters on through the output register.
// The back end takes a character through dispatch and store, a newline through dispatch and
//   a line-end step; a '?', a message end, each wrap or trim space and a width shrink mid-line
//   add steps; lead bytes are not queued; a stalled output holds the back end.
// Reset: synchronous, clears line state, queue and output; width 25, wrap limit 3.
//   The line store is not cleared.
module text_line_wrapper_utf8_replace
   import tlw_pkg::*;
#(
   parameter int MAX_LINE = TLW_MAX_LINE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlw_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlw_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_addr,
   input  logic [CSR_DW-1:0] csr_wdata
);

   logic [5:0] line_width_ff;
   logic [2:0] max_wraps_ff;
   logic       q_full;
   logic       push;
   tlw_op_type push_op;
   logic       pop;
   tlw_op_type head;
   logic       head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RST;
         max_wraps_ff  <= MAX_WRAPS_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LINE_WIDTH: line_width_ff <= csr_wdata[5:0];
            CSR_MAX_WRAPS:  max_wraps_ff  <= csr_wdata[2:0];
            default:        line_width_ff <= line_width_ff;
         endcase
      end
   end

   tlw_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_op   (push_op)
   );

   tlw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (q_full),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid)
   );

   tlw_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .line_width (line_width_ff),
      .max_wraps  (max_wraps_ff),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### src/tlw_ram.sv
`timescale 1ns / 1ps
module tlw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

### src/tlw_front.sv
`timescale 1ns / 1ps
module tlw_front
   import tlw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  tlw_req_type req_data,
   input  logic        q_full,
   output logic        push,
   output tlw_op_type  push_op
);

   localparam logic [7:0] MASK_HI   = 8'h80;
   localparam logic [7:0] MASK_L2   = 8'hE0;
   localparam logic [7:0] LEAD_L2   = 8'hC0;
   localparam logic [7:0] MASK_L3   = 8'hF0;
   localparam logic [7:0] LEAD_L3   = 8'hE0;
   localparam logic [7:0] MASK_L4   = 8'hF8;
   localparam logic [7:0] LEAD_L4   = 8'hF0;

   logic [1:0] pending_ff;
   logic [1:0] pending_in;
   tlw_op_type op;
   logic [7:0] b;
   logic       accept;

   assign b         = req_data.text_byte;
   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      op         = '{qmark: 1'b0, act: ACT_NONE, code: b, last: req_data.message_end};
      pending_in = pending_ff;
      if ((b & MASK_HI) != 8'h00) begin
         priority if (pending_ff != 2'd0) begin
            pending_in = pending_ff - 2'd1;
            op.qmark   = (pending_ff == 2'd1);
         end else if ((b & MASK_L2) == LEAD_L2) begin
            pending_in = 2'd1;
         end else if ((b & MASK_L3) == LEAD_L3) begin
            pending_in = 2'd2;
         end else if ((b & MASK_L4) == LEAD_L4) begin
            pending_in = 2'd3;
         end else begin
            op.qmark = 1'b1;
         end
      end else begin
         if (pending_ff != 2'd0) begin
            pending_in = 2'd0;
            op.qmark   = 1'b1;
         end
         op.act = (b == CHAR_NL) ? ACT_EOL : ACT_CHAR;
      end
      if (req_data.message_end) begin
         pending_in = 2'd0;
      end
   end

   // lead bytes that change nothing downstream are not queued
   assign push    = accept && (op.qmark || (op.act != ACT_NONE) || op.last);
   assign push_op = op;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 2'd0;
      end else if (accept) begin
         pending_ff <= pending_in;
      end
   end

endmodule

### src/tlw_queue.sv
`timescale 1ns / 1ps
module tlw_queue
   import tlw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  tlw_op_type push_op,
   output logic       full,
   input  logic       pop,
   output tlw_op_type head,
   output logic       head_valid
);

   localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CW = $clog2(QDEPTH + 1);

   tlw_op_type      mem_ff [QDEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   cnt_ff;
   logic [CW-1:0]   cnt_in;
   logic            do_push;
   logic            do_pop;

   assign full       = (cnt_ff == CW'(QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QDEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QDEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

### src/tlw_back.sv
`timescale 1ns / 1ps
module tlw_back
   import tlw_pkg::*;
#(
   parameter int MAX_LINE = TLW_MAX_LINE
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [5:0]  line_width,
   input  logic [2:0]  max_wraps,
   input  tlw_op_type  head,
   input  logic        head_valid,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output tlw_rsp_type rsp_data
);

   localparam int WW = $clog2(MAX_LINE + 1);
   localparam int AW = $clog2(MAX_LINE);
   localparam int CW = (WW > 6) ? WW : 6;

   tlw_state_type state_ff;
   tlw_state_type state_in;
   tlw_op_type    work_ff;
   tlw_op_type    work_in;
   tlw_op_type    src;
   logic [7:0]    cur_c_ff;
   logic [7:0]    cur_c_in;
   logic [7:0]    held_ff;
   logic [7:0]    held_in;
   logic [WW-1:0] lc_ff;
   logic [WW-1:0] lc_in;
   logic [WW-1:0] lc_inc;
   logic [2:0]    wc_ff;
   logic [2:0]    wc_in;
   logic          drop_ff;
   logic          drop_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   tlw_rsp_type   rsp_data_ff;
   tlw_rsp_type   rsp_data_in;

   logic [CW-1:0] lw_c;
   logic [CW-1:0] w_c;
   logic [WW-1:0] w;
   logic          work_empty;
   logic          out_free;
   logic          clamp;
   logic          trim;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr;
   logic [7:0]    ram_rdata;

   function automatic tlw_rsp_type mk_rsp(input logic [7:0] code, input logic valid,
                                          input logic lend, input logic ovf);
      tlw_rsp_type r;
      r.char_code     = code;
      r.char_valid    = valid;
      r.line_end      = lend;
      r.line_overflow = ovf;
      return r;
   endfunction

   tlw_ram #(
      .WIDTH (8),
      .DEPTH (MAX_LINE)
   ) u_line_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      lw_c = CW'(line_width);
      if (lw_c < CW'(2)) begin
         w_c = CW'(2);
      end else if (lw_c > CW'(MAX_LINE)) begin
         w_c = CW'(MAX_LINE);
      end else begin
         w_c = lw_c;
      end
   end

   assign w          = WW'(w_c);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign work_empty = !work_ff.qmark && (work_ff.act == ACT_NONE) && !work_ff.last;
   assign src        = (work_empty && head_valid) ? head : work_ff;
   assign clamp      = (lc_ff >= w);
   assign lc_inc     = lc_ff + WW'(1);
   assign trim       = (wc_ff >= max_wraps);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_DISPATCH: begin
            priority if (src.qmark && !drop_ff) begin
               state_in = ST_PUT;
            end else if ((src.act == ACT_CHAR) && !drop_ff) begin
               state_in = ST_PUT;
            end else if ((src.act == ACT_EOL) && !drop_ff) begin
               state_in = ST_EOL;
            end else if (src.last) begin
               state_in = ST_FLUSH;
            end else begin
               state_in = ST_DISPATCH;
            end
         end
         ST_PUT: begin
            priority if (clamp) begin
               state_in = ST_RDWAIT;
            end else if ((lc_ff != '0) && !out_free) begin
               state_in = ST_PUT;
            end else if (lc_inc >= w) begin
               state_in = ST_WRAP;
            end else begin
               state_in = ST_DISPATCH;
            end
         end
         ST_RDWAIT: state_in = ST_PUT;
         ST_WRAP: begin
            if (out_free) begin
               state_in = trim ? ST_TRIM2 : ST_DISPATCH;
            end
         end
         ST_TRIM2, ST_EOL: begin
            if (out_free) begin
               state_in = ST_DISPATCH;
            end
         end
         ST_FLUSH: begin
            if (drop_ff || (lc_ff == '0) || out_free) begin
               state_in = ST_DISPATCH;
            end
         end
         default: state_in = ST_DISPATCH;
      endcase
   end

   // datapath and outputs
   always_comb begin
      work_in      = work_ff;
      cur_c_in     = cur_c_ff;
      held_in      = held_ff;
      lc_in        = lc_ff;
      wc_in        = wc_ff;
      drop_in      = drop_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_waddr    = lc_ff[AW-1:0];
      ram_wdata    = cur_c_ff;
      ram_raddr    = AW'(w - WW'(2));
      pop          = 1'b0;
      unique case (state_ff)
         ST_DISPATCH: begin
            pop     = work_empty && head_valid;
            work_in = src;
            priority if (src.qmark && !drop_ff) begin
               cur_c_in      = CHAR_QMARK;
               work_in.qmark = 1'b0;
            end else if ((src.act == ACT_CHAR) && !drop_ff) begin
               cur_c_in      = src.code;
               work_in.qmark = 1'b0;
               work_in.act   = ACT_NONE;
            end else if ((src.act == ACT_EOL) && !drop_ff) begin
               work_in.qmark = 1'b0;
               work_in.act   = ACT_NONE;
            end else begin
               work_in.qmark = 1'b0;
               work_in.act   = ACT_NONE;
               work_in.last  = 1'b0;
            end
         end
         ST_PUT: begin
            priority if (clamp) begin
               // width shrank mid-line: fall back to width-1 and refetch the last char
               lc_in = w - WW'(1);
            end else if ((lc_ff == '0) || out_free) begin
               if (lc_ff != '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = mk_rsp(held_ff, 1'b1, 1'b0, 1'b0);
               end
               ram_we  = 1'b1;
               held_in = cur_c_ff;
               lc_in   = lc_inc;
               if (lc_inc >= w) begin
                  wc_in = wc_ff + 3'd1;
               end
            end else begin
               lc_in = lc_ff;
            end
         end
         ST_RDWAIT: held_in = ram_rdata;
         ST_WRAP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (trim) begin
                  rsp_data_in = mk_rsp(CHAR_SPACE, 1'b1, 1'b0, 1'b1);
               end else begin
                  rsp_data_in = mk_rsp(held_ff, 1'b1, 1'b1, 1'b0);
                  ram_we      = 1'b1;
                  ram_waddr   = '0;
                  ram_wdata   = CHAR_SPACE;
                  held_in     = CHAR_SPACE;
                  lc_in       = WW'(1);
               end
            end
         end
         ST_TRIM2: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mk_rsp(CHAR_SPACE, 1'b1, 1'b1, 1'b1);
               lc_in        = '0;
               drop_in      = 1'b1;
            end
         end
         ST_EOL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (lc_ff == '0) begin
                  rsp_data_in = mk_rsp(8'h00, 1'b0, 1'b1, 1'b0);
               end else begin
                  rsp_data_in = mk_rsp(held_ff, 1'b1, 1'b1, 1'b0);
               end
               lc_in = '0;
            end
         end
         ST_FLUSH: begin
            if (drop_ff || (lc_ff == '0) || out_free) begin
               if (!drop_ff && (lc_ff != '0)) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = mk_rsp(held_ff, 1'b1, 1'b1, 1'b0);
               end
               lc_in   = '0;
               wc_in   = 3'd0;
               drop_in = 1'b0;
            end
         end
         default: pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DISPATCH;
         work_ff      <= '{qmark: 1'b0, act: ACT_NONE, code: 8'h00, last: 1'b0};
         lc_ff        <= '0;
         wc_ff        <= 3'd0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         work_ff      <= work_in;
         lc_ff        <= lc_in;
         wc_ff        <= wc_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_c_ff    <= cur_c_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_lc_bound: assert property (@(posedge clock) disable iff (reset)
      lc_ff <= WW'(MAX_LINE))
      else $error("line count beyond store depth");

   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (lc_ff == '0))
      else $error("open line while dropping");

   a_rdwait_src: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RDWAIT) |-> ($past(state_ff) == ST_PUT))
      else $error("store read not issued from put");

   a_trim_src: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIM2) |-> ($past(state_ff) == ST_WRAP || $past(state_ff) == ST_TRIM2))
      else $error("trim without wrap");

endmodule

### bench/tb_text_line_wrapper_utf8_replace.sv
`timescale 1ns / 1ps
module tb_text_line_wrapper_utf8_replace;
   import tlw_pkg::*;

   localparam int QUIET_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 40;

   class wrap_scoreboard;
      logic [7:0]  open_line [TLW_MAX_LINE];
      int          fill;
      int          seq_left;
      int          wraps;
      bit          trimmed;
      logic [5:0]  width_reg;
      logic [2:0]  wrap_limit;
      tlw_rsp_type chars_due [$];
      int          mismatches;
      int          checked;
      int          words_in;
      int          reg_writes;

      function new();
         width_reg  = LINE_WIDTH_RST;
         wrap_limit = MAX_WRAPS_RST;
         mismatches = 0;
         checked    = 0;
         words_in   = 0;
         reg_writes = 0;
         clear_message();
      endfunction

      function void clear_message();
         fill     = 0;
         seq_left = 0;
         wraps    = 0;
         trimmed  = 1'b0;
      endfunction

      function void write_reg(logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] data);
         if (addr == CSR_LINE_WIDTH) begin
            width_reg = data[5:0];
         end else if (addr == CSR_MAX_WRAPS) begin
            wrap_limit = data[2:0];
         end
         reg_writes++;
      endfunction

      function int eff_width();
         int w;
         w = width_reg;
         if (w < 2) w = 2;
         if (w > TLW_MAX_LINE) w = TLW_MAX_LINE;
         return w;
      endfunction

      function void push_char(logic [7:0] code, bit valid, bit eol, bit ovf);
         tlw_rsp_type r;
         r.char_code     = code;
         r.char_valid    = valid;
         r.line_end      = eol;
         r.line_overflow = ovf;
         chars_due.push_back(r);
      endfunction

      // last stored char is held back so it can carry the line end
      function void append(logic [7:0] c);
         int w;
         w = eff_width();
         if (trimmed) return;
         if (fill >= w) fill = w - 1;
         if (fill > 0) push_char(open_line[fill-1], 1'b1, 1'b0, 1'b0);
         open_line[fill] = c;
         fill++;
         if (fill >= w) begin
            wraps = (wraps + 1) & 7;
            if (wraps >= wrap_limit) begin
               push_char(CHAR_SPACE, 1'b1, 1'b0, 1'b1);
               push_char(CHAR_SPACE, 1'b1, 1'b1, 1'b1);
               fill    = 0;
               trimmed = 1'b1;
               return;
            end
            push_char(c, 1'b1, 1'b1, 1'b0);
            open_line[0] = CHAR_SPACE;
            fill         = 1;
         end
      endfunction

      function void close_line();
         if (fill == 0) begin
            push_char(8'h00, 1'b0, 1'b1, 1'b0);
         end else begin
            push_char(open_line[fill-1], 1'b1, 1'b1, 1'b0);
            fill = 0;
         end
      endfunction

      function void note_word(tlw_req_type w);
         logic [7:0] b;
         b = w.text_byte;
         words_in++;
         if (!trimmed) begin
            if (b[7]) begin
               if (seq_left > 0) begin
                  seq_left--;
                  if (seq_left == 0) append(CHAR_QMARK);
               end else if ((b & 8'hE0) == 8'hC0) begin
                  seq_left = 1;
               end else if ((b & 8'hF0) == 8'hE0) begin
                  seq_left = 2;
               end else if ((b & 8'hF8) == 8'hF0) begin
                  seq_left = 3;
               end else begin
                  append(CHAR_QMARK);
               end
            end else begin
               if (seq_left > 0) begin
                  seq_left = 0;
                  append(CHAR_QMARK);
               end
               if (!trimmed) begin
                  if (b == CHAR_NL) close_line();
                  else append(b);
               end
            end
         end
         if (w.message_end) begin
            if (!trimmed && fill > 0) push_char(open_line[fill-1], 1'b1, 1'b1, 1'b0);
            clear_message();
         end
      endfunction

      function void check_char(tlw_rsp_type got);
         tlw_rsp_type want;
         checked++;
         if (chars_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("char %0d unexpected: code %02h valid %0b end %0b ovf %0b", checked,
                        got.char_code, got.char_valid, got.line_end, got.line_overflow);
            return;
         end
         want = chars_due.pop_front();
         if (got.char_code !== want.char_code || got.char_valid !== want.char_valid ||
             got.line_end !== want.line_end || got.line_overflow !== want.line_overflow) begin
            mismatches++;
            if (mismatches <= 10)
               $display("char %0d: expected code %02h valid %0b end %0b ovf %0b,",
                        checked, want.char_code, want.char_valid, want.line_end,
                        want.line_overflow, " got code %02h valid %0b end %0b ovf %0b",
                        got.char_code, got.char_valid, got.line_end, got.line_overflow);
         end
      endfunction
   endclass

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   tlw_req_type       req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   tlw_rsp_type       rsp_data;
   logic              csr_we    = 1'b0;
   logic [CSR_AW-1:0] csr_addr  = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   wrap_scoreboard sb;
   tlw_req_type    msg_q [$];
   int             send_pct     = 0;
   int             stall_pct    = 0;
   int             quiet_cycles = 0;
   bit             req_fired    = 1'b0;

   text_line_wrapper_utf8_replace u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      req_fired = 1'b0;
      if (!reset) begin
         req_fired = req_valid && req_ready;
         if (csr_we) sb.write_reg(csr_addr, csr_wdata);
         if (req_fired) sb.note_word(req_data);
         if (rsp_valid && rsp_ready) sb.check_char(rsp_data);
         if (req_fired || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Stuck for %0d cycles with no word moving", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
   end

   function void queue_text(logic [7:0] b, bit last);
      tlw_req_type r;
      r.text_byte   = b;
      r.message_end = last;
      msg_q.push_back(r);
   endfunction

   function logic [7:0] lead_byte(int n_cont);
      if (n_cont == 1) return 8'hC0 | 8'($urandom_range(31));
      if (n_cont == 2) return 8'hE0 | 8'($urandom_range(15));
      return 8'hF0 | 8'($urandom_range(7));
   endfunction

   function logic [7:0] cont_byte();
      return 8'h80 | 8'($urandom_range(63));
   endfunction

   function void make_message();
      int          n_tok;
      int          kind;
      int          n_cont;
      int          cut;
      tlw_req_type r;
      n_tok = ($urandom_range(4) == 0) ? $urandom_range(40, 12) : $urandom_range(10, 1);
      for (int k = 0; k < n_tok; k++) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            queue_text(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
         end else if (kind < 58) begin
            queue_text(CHAR_NL, 1'b0);
         end else if (kind < 80) begin
            n_cont = $urandom_range(3, 1);
            queue_text(lead_byte(n_cont), 1'b0);
            if (kind < 73) begin
               for (int i = 0; i < n_cont; i++) queue_text(cont_byte(), 1'b0);
            end else begin
               // sequence cut off by an ASCII byte
               cut = $urandom_range(n_cont - 1, 0);
               for (int i = 0; i < cut; i++) queue_text(cont_byte(), 1'b0);
               queue_text(8'($urandom_range(8'h7F, 1)), 1'b0);
            end
         end else if (kind < 87) begin
            if ($urandom_range(1) == 1) queue_text(cont_byte(), 1'b0);
            else queue_text(8'($urandom_range(8'hFF, 8'hF8)), 1'b0);
         end else begin
            queue_text(8'($urandom_range(255, 1)), 1'b0);
         end
      end
      if ($urandom_range(9) == 0) queue_text(lead_byte($urandom_range(3, 1)), 1'b0);
      r = msg_q.pop_back();
      r.message_end = 1'b1;
      msg_q.push_back(r);
   endfunction

   // all driving tasks start and end at a falling edge
   task automatic send_word(tlw_req_type w);
      while ($urandom_range(99) < send_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(negedge clock);
      while (!req_fired) @(negedge clock);
   endtask

   task automatic send_queued();
      while (msg_q.size() != 0) send_word(msg_q.pop_front());
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.chars_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_config(logic [5:0] width, logic [2:0] limit);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_LINE_WIDTH;
      csr_wdata <= CSR_DW'(width);
      @(negedge clock);
      csr_addr  <= CSR_MAX_WRAPS;
      csr_wdata <= CSR_DW'(limit);
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(logic [5:0] width, logic [2:0] limit, int s_pct, int r_pct,
                            int n_words, bit hold_midway);
      settle();
      set_config(width, limit);
      send_pct  = s_pct;
      stall_pct = r_pct;
      for (int i = 0; i < n_words; i++) begin
         if (hold_midway && i == n_words / 2) settle();
         if (msg_q.size() == 0) make_message();
         send_word(msg_q.pop_front());
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset widths; UTF-8 forms, strays, cut-off, empty line, unfinished at end
      queue_text(8'h41, 1'b0);
      queue_text(8'hC3, 1'b0);
      queue_text(8'hA9, 1'b0);
      queue_text(8'hE2, 1'b0);
      queue_text(8'h82, 1'b0);
      queue_text(8'hAC, 1'b0);
      queue_text(8'hF0, 1'b0);
      queue_text(8'h9F, 1'b0);
      queue_text(8'h98, 1'b0);
      queue_text(8'h80, 1'b0);
      queue_text(8'h80, 1'b0);
      queue_text(8'hFF, 1'b0);
      queue_text(8'hC3, 1'b0);
      queue_text(8'h42, 1'b0);
      queue_text(CHAR_NL, 1'b0);
      queue_text(CHAR_NL, 1'b1);
      queue_text(8'hF0, 1'b0);
      queue_text(8'h9F, 1'b1);
      send_queued();

      // width below range and zero wrap limit: trim on first wrap, rest dropped
      settle();
      set_config(6'd0, 3'd0);
      queue_text(8'h61, 1'b0);
      queue_text(8'h62, 1'b0);
      queue_text(8'h63, 1'b0);
      queue_text(8'h64, 1'b1);
      send_queued();

      run_phase(6'd63, 3'd7,  0,  0, 18, 1'b0);
      run_phase(6'd2,  3'd1, 79,  0, 18, 1'b0);
      run_phase(6'd13, 3'd2,  0, 79, 18, 1'b0);
      run_phase(6'd32, 3'd7, 27, 27, 18, 1'b1);
      run_phase(6'd1,  3'd4, 27, 27, 18, 1'b0);
      run_phase(6'd33, 3'd5,  0, 79, 18, 1'b0);
      settle();

      $display("Sent %0d words and checked %0d characters across %0d register writes,",
               sb.words_in, sb.checked, sb.reg_writes);
      $display("widths 0..63 and wrap limits 0..7, with sender gaps and receiver stalls");
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
src/tlw_pkg.sv
src/tlw_ram.sv
src/tlw_front.sv
src/tlw_queue.sv
src/tlw_back.sv
src/text_line_wrapper_utf8_replace.sv
bench/tb_text_line_wrapper_utf8_replace.sv
